[src/ktfr_pkg.sv]
// ----------------------------------------------------------------------------
// ktfr_pkg
// Shared types and constants of the bus frame receiver: parser states,
// controller/datapath command and status bundles, start byte codes.
// ----------------------------------------------------------------------------
package ktfr_pkg;

   // item kinds on the input channel (tuser)
   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   // start byte recognition
   localparam logic [7:0] START_MASK     = 8'hD3;
   localparam logic [7:0] START_STANDARD = 8'h90;
   localparam logic [7:0] START_EXTENDED = 8'h10;

   // header length and the positions of the length fields
   localparam int unsigned HEADER_BYTES = 7;
   localparam int unsigned STD_LEN_POS  = 5;
   localparam int unsigned EXT_LEN_POS  = 6;
   localparam logic [8:0]  STD_OVERHEAD = 9'd8;
   localparam logic [8:0]  EXT_OVERHEAD = 9'd9;
   localparam int unsigned TOTAL_W      = 9;

   // saturation point of the tick counter
   localparam logic [7:0] GAP_MAX = 8'hFF;

   // register map
   localparam logic REG_FRAME_GAP_LIMIT = 1'b0;
   localparam logic REG_QUIET_GAP       = 1'b1;
   localparam logic [7:0] FRAME_GAP_LIMIT_RESET = 8'd80;
   localparam logic [7:0] QUIET_GAP_RESET       = 8'd2;

   typedef enum logic [2:0] {
      ST_WAIT,
      ST_HEADER,
      ST_DATA,
      ST_DISCARD,
      ST_REPLAY
   } ktfr_state_type;

   // controller to datapath
   typedef struct packed {
      logic tick;        // tick item accepted
      logic byte_in;     // byte item accepted (clears gap counter)
      logic take_start;  // restart frame with this byte
      logic store_byte;  // append byte to buffer
      logic fold_xor;    // fold byte into running checksum
      logic replay_go;   // start replaying the buffered frame
   } ktfr_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_start;     // byte is a start byte
      logic gap_over;     // header gap exceeded
      logic hdr_full;     // this byte completes the header
      logic buf_full;     // no room for another data byte
      logic frame_end;    // this byte is the closing byte
      logic csum_ok;      // closing byte matches checksum
      logic quiet_hit;    // this tick ends the quiet period
      logic replay_busy;  // buffer reads still outstanding
   } ktfr_stat_type;

endpackage

[src/knx_tp_frame_receiver_core.sv]
// ----------------------------------------------------------------------------
// knx_tp_frame_receiver_core
// Assembles bus data frames from received bytes and millisecond ticks and
// replays each frame with a good checksum byte by byte.
// ----------------------------------------------------------------------------
// Every input item (byte or tick) is taken when offered, except during replay:
// after the closing byte of a good frame of N bytes the input is held off
// while the frame is read back from the frame buffer, one RAM read per cycle
// as long as the result side is ready; backpressure holds the reads back.
// Results leave through an output register, so the replay of one frame can
// overlap the start of the next. The frame buffer needs no clearing after
// reset. Registers: byte address 0 holds the header gap limit in ticks,
// address 4 the quiet gap that ends discarding after a bad frame.
module knx_tp_frame_receiver_core #(
   parameter int BUFFER_BYTES = 64
) (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] data_byte
   input  logic        req_tuser,    // [0] kind
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,    // [7:0] frame_byte, [13:8] byte_index, [15:14] zero
   output logic        rsp_tlast,
   // configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   ktfr_pkg::ktfr_cmd_type  cmd;
   ktfr_pkg::ktfr_stat_type stat;

   logic [7:0] gap_limit_ff, gap_limit_in;
   logic [7:0] quiet_ff, quiet_in;
   logic       csr_wr;
   logic [7:0] out_byte;
   logic [5:0] out_index;

   // register file
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      gap_limit_in = gap_limit_ff;
      quiet_in     = quiet_ff;
      if (csr_wr) begin
         unique case (csr_paddr[2])
            ktfr_pkg::REG_FRAME_GAP_LIMIT: gap_limit_in = csr_pwdata[7:0];
            ktfr_pkg::REG_QUIET_GAP:       quiet_in     = csr_pwdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_limit_ff <= ktfr_pkg::FRAME_GAP_LIMIT_RESET;
         quiet_ff     <= ktfr_pkg::QUIET_GAP_RESET;
      end else begin
         gap_limit_ff <= gap_limit_in;
         quiet_ff     <= quiet_in;
      end
   end

   // read back
   always_comb begin
      unique case (csr_paddr[2])
         ktfr_pkg::REG_FRAME_GAP_LIMIT: csr_prdata = {24'd0, gap_limit_ff};
         ktfr_pkg::REG_QUIET_GAP:       csr_prdata = {24'd0, quiet_ff};
         default:                       csr_prdata = '0;
      endcase
   end

   ktfr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_kind   (req_tuser),
      .stat       (stat),
      .req_tready (req_tready),
      .cmd        (cmd)
   );

   ktfr_dpath #(
      .BUFFER_BYTES (BUFFER_BYTES)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .in_byte         (req_tdata),
      .frame_gap_limit (gap_limit_ff),
      .quiet_gap       (quiet_ff),
      .stat            (stat),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .out_byte        (out_byte),
      .out_index       (out_index),
      .out_last        (rsp_tlast)
   );

   assign rsp_tdata = {2'b00, out_index, out_byte};

endmodule

[src/ktfr_ram.sv]
// ----------------------------------------------------------------------------
// ktfr_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ktfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[src/ktfr_ctrl.sv]
// ----------------------------------------------------------------------------
// ktfr_ctrl
// Parser state machine: start hunt, header, data, discard and replay.
// ----------------------------------------------------------------------------
module ktfr_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_kind,
   input  ktfr_pkg::ktfr_stat_type stat,
   output logic                   req_tready,
   output ktfr_pkg::ktfr_cmd_type  cmd
);

   ktfr_pkg::ktfr_state_type state_ff, state_in;
   logic acc_byte;
   logic acc_tick;

   assign req_tready = (state_ff != ktfr_pkg::ST_REPLAY);
   assign acc_byte   = req_tvalid & req_tready & (req_kind == ktfr_pkg::KIND_BYTE);
   assign acc_tick   = req_tvalid & req_tready & (req_kind == ktfr_pkg::KIND_TICK);

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ktfr_pkg::ST_WAIT;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ktfr_pkg::ST_WAIT: begin
            if (acc_byte && stat.is_start) begin
               state_in = ktfr_pkg::ST_HEADER;
            end
         end
         ktfr_pkg::ST_HEADER: begin
            if (acc_byte) begin
               if (stat.gap_over) begin
                  state_in = stat.is_start ? ktfr_pkg::ST_HEADER : ktfr_pkg::ST_WAIT;
               end else if (stat.hdr_full) begin
                  state_in = ktfr_pkg::ST_DATA;
               end
            end
         end
         ktfr_pkg::ST_DATA: begin
            if (acc_byte) begin
               if (stat.buf_full) begin
                  state_in = ktfr_pkg::ST_DISCARD;
               end else if (stat.frame_end) begin
                  state_in = stat.csum_ok ? ktfr_pkg::ST_REPLAY : ktfr_pkg::ST_DISCARD;
               end
            end
         end
         ktfr_pkg::ST_DISCARD: begin
            if (acc_tick && stat.quiet_hit) begin
               state_in = ktfr_pkg::ST_WAIT;
            end
         end
         ktfr_pkg::ST_REPLAY: begin
            if (!stat.replay_busy) begin
               state_in = ktfr_pkg::ST_WAIT;
            end
         end
         default: state_in = ktfr_pkg::ST_DISCARD;
      endcase
   end

   // datapath commands
   always_comb begin
      cmd            = '0;
      cmd.tick       = acc_tick;
      cmd.byte_in    = acc_byte;
      unique case (state_ff)
         ktfr_pkg::ST_WAIT: begin
            cmd.take_start = acc_byte;
         end
         ktfr_pkg::ST_HEADER: begin
            if (acc_byte) begin
               if (stat.gap_over) begin
                  cmd.take_start = 1'b1;
               end else begin
                  cmd.store_byte = 1'b1;
                  cmd.fold_xor   = 1'b1;
               end
            end
         end
         ktfr_pkg::ST_DATA: begin
            if (acc_byte && !stat.buf_full) begin
               cmd.store_byte = 1'b1;
               cmd.fold_xor   = !stat.frame_end;
               cmd.replay_go  = stat.frame_end & stat.csum_ok;
            end
         end
         ktfr_pkg::ST_DISCARD: begin
         end
         ktfr_pkg::ST_REPLAY: begin
         end
         default: begin
         end
      endcase
   end

endmodule

[src/ktfr_dpath.sv]
// ----------------------------------------------------------------------------
// ktfr_dpath
// Frame datapath: gap counter, byte count, checksum, length fields, frame
// buffer and the replay read pipeline feeding the output register.
// ----------------------------------------------------------------------------
module ktfr_dpath #(
   parameter int BUFFER_BYTES = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  ktfr_pkg::ktfr_cmd_type  cmd,
   input  logic [7:0]              in_byte,
   input  logic [7:0]              frame_gap_limit,
   input  logic [7:0]              quiet_gap,
   output ktfr_pkg::ktfr_stat_type stat,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [7:0]              out_byte,
   output logic [5:0]              out_index,
   output logic                    out_last
);

   localparam int CW   = $clog2(BUFFER_BYTES);
   localparam int CMPW = (CW + 1 > ktfr_pkg::TOTAL_W) ? CW + 1 : ktfr_pkg::TOTAL_W;
   localparam int IW   = (CW > 6) ? CW : 6;

   logic [7:0]    gap_ff, gap_in, gap_inc;
   logic [CW-1:0] count_ff, count_in;
   logic [7:0]    xor_ff, xor_in;
   logic          ext_ff, ext_in;
   logic [3:0]    len_std_ff, len_std_in;
   logic [7:0]    len_ext_ff, len_ext_in;
   logic [8:0]    total;
   logic [7:0]    masked;

   logic          ram_we;
   logic [CW-1:0] ram_waddr;
   logic [7:0]    ram_rdata;

   logic          rd_act_ff, rd_act_in;
   logic [CW-1:0] rd_idx_ff, rd_idx_in;
   logic          issue;
   logic          adv;
   logic          is_last_rd;
   logic [IW-1:0] rd_idx_w;
   logic          p1_ff, p1_in;
   logic [5:0]    p1_idx_ff, p1_idx_in;
   logic          p1_last_ff, p1_last_in;
   logic          out_v_ff, out_v_in;
   logic [7:0]    out_byte_ff, out_byte_in;
   logic [5:0]    out_idx_ff, out_idx_in;
   logic          out_last_ff, out_last_in;

   // status toward the controller
   assign masked  = in_byte & ktfr_pkg::START_MASK;
   assign gap_inc = (gap_ff == ktfr_pkg::GAP_MAX) ? gap_ff : gap_ff + 8'd1;
   assign total   = ext_ff ? ({1'b0, len_ext_ff} + ktfr_pkg::EXT_OVERHEAD)
                           : ({5'd0, len_std_ff} + ktfr_pkg::STD_OVERHEAD);

   always_comb begin
      stat.is_start    = (masked == ktfr_pkg::START_STANDARD) ||
                         (masked == ktfr_pkg::START_EXTENDED);
      stat.gap_over    = gap_ff > frame_gap_limit;
      stat.hdr_full    = count_ff == CW'(ktfr_pkg::HEADER_BYTES - 1);
      stat.buf_full    = count_ff >= CW'(BUFFER_BYTES - 2);
      stat.frame_end   = (CMPW'(count_ff) + CMPW'(1)) == CMPW'(total);
      stat.csum_ok     = in_byte == ~xor_ff;
      stat.quiet_hit   = gap_inc >= quiet_gap;
      stat.replay_busy = rd_act_ff;
   end

   // frame assembly state
   always_comb begin
      gap_in     = gap_ff;
      count_in   = count_ff;
      xor_in     = xor_ff;
      ext_in     = ext_ff;
      len_std_in = len_std_ff;
      len_ext_in = len_ext_ff;
      if (cmd.tick) begin
         gap_in = gap_inc;
      end else if (cmd.byte_in) begin
         gap_in = '0;
      end
      if (cmd.take_start) begin
         if (stat.is_start) begin
            count_in = CW'(1);
            xor_in   = in_byte;
            ext_in   = masked == ktfr_pkg::START_EXTENDED;
         end else begin
            count_in = '0;
            xor_in   = '0;
         end
      end else if (cmd.store_byte) begin
         count_in = count_ff + CW'(1);
         if (cmd.fold_xor) begin
            xor_in = xor_ff ^ in_byte;
         end
         if (count_ff == CW'(ktfr_pkg::STD_LEN_POS)) begin
            len_std_in = in_byte[3:0];
         end
         if (count_ff == CW'(ktfr_pkg::EXT_LEN_POS)) begin
            len_ext_in = in_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff   <= '0;
         count_ff <= '0;
         xor_ff   <= '0;
         ext_ff   <= 1'b0;
      end else begin
         gap_ff   <= gap_in;
         count_ff <= count_in;
         xor_ff   <= xor_in;
         ext_ff   <= ext_in;
      end
      len_std_ff <= len_std_in;
      len_ext_ff <= len_ext_in;
   end

   // frame buffer
   assign ram_we    = (cmd.take_start & stat.is_start) | cmd.store_byte;
   assign ram_waddr = cmd.take_start ? '0 : count_ff;

   ktfr_ram #(
      .WIDTH (8),
      .DEPTH (BUFFER_BYTES)
   ) u_frame_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (in_byte),
      .re    (issue),
      .raddr (rd_idx_ff),
      .rdata (ram_rdata)
   );

   // replay: read issue, RAM output stage, output register
   assign adv        = !out_v_ff || rsp_tready;
   assign issue      = rd_act_ff && (!p1_ff || adv);
   assign is_last_rd = (rd_idx_ff + CW'(1)) == count_ff;
   assign rd_idx_w   = IW'(rd_idx_ff);

   always_comb begin
      rd_act_in   = rd_act_ff;
      rd_idx_in   = rd_idx_ff;
      p1_in       = p1_ff & !adv;
      p1_idx_in   = p1_idx_ff;
      p1_last_in  = p1_last_ff;
      out_v_in    = out_v_ff;
      out_byte_in = out_byte_ff;
      out_idx_in  = out_idx_ff;
      out_last_in = out_last_ff;
      if (cmd.replay_go) begin
         rd_act_in = 1'b1;
         rd_idx_in = '0;
      end else if (issue) begin
         rd_idx_in = rd_idx_ff + CW'(1);
         if (is_last_rd) begin
            rd_act_in = 1'b0;
         end
      end
      if (issue) begin
         p1_in      = 1'b1;
         p1_idx_in  = rd_idx_w[5:0];
         p1_last_in = is_last_rd;
      end
      if (adv) begin
         out_v_in    = p1_ff;
         out_byte_in = ram_rdata;
         out_idx_in  = p1_idx_ff;
         out_last_in = p1_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_act_ff <= 1'b0;
         p1_ff     <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         rd_act_ff <= rd_act_in;
         p1_ff     <= p1_in;
         out_v_ff  <= out_v_in;
      end
      rd_idx_ff   <= rd_idx_in;
      p1_idx_ff   <= p1_idx_in;
      p1_last_ff  <= p1_last_in;
      out_byte_ff <= out_byte_in;
      out_idx_ff  <= out_idx_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_v_ff;
   assign out_byte   = out_byte_ff;
   assign out_index  = out_idx_ff;
   assign out_last   = out_last_ff;

`ifndef SYNTH
   // buffer is never written while a replay is still reading it
   a_no_write_in_replay: assert property (@(posedge clock) disable iff (reset)
      rd_act_ff |-> !ram_we)
      else $error("frame buffer written during replay");

   // byte count stays inside the usable buffer
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(BUFFER_BYTES - 2))
      else $error("byte count beyond buffer");

   // only complete frames (at least eight bytes) are replayed
   a_replay_len: assert property (@(posedge clock) disable iff (reset)
      cmd.replay_go |=> (rd_act_ff && count_ff >= CW'(8)))
      else $error("replay of a short frame");
`endif

endmodule
